@@ design/path_great_circle_distance_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the path great-circle distance unit
// Wrappers for concurrent checks, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef PATH_GREAT_CIRCLE_DISTANCE_UNIT_MACROS_SVH
`define PATH_GREAT_CIRCLE_DISTANCE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define PGCD_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define PGCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PGCD_ASSERT_HOLDS(lbl, ante, cons, msg)
`define PGCD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ design/pgcd_pkg.sv @@
// ----------------------------------------------------------------------------
// pgcd_pkg
// Types, constants and the CORDIC angle table of the distance unit.
// ----------------------------------------------------------------------------
package pgcd_pkg;

  localparam int LAT_W   = 28;
  localparam int LON_W   = 29;
  localparam int SEG_W   = 31;
  localparam int TOTAL_W = 48;
  localparam int RAD_W   = 23;
  localparam int LIMIT_W = 32;
  localparam int CFG_W   = 32;
  localparam int CD_W    = 34;  // CORDIC datapath width
  localparam int SQ_W    = 61;  // square root operand width

  localparam logic REG_EARTH_RADIUS = 1'b0;
  localparam logic REG_LIMIT        = 1'b1;

  localparam logic [RAD_W-1:0]   RADIUS_RESET = 23'd6371000;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 32'd10000;

  localparam logic signed [31:0] ANG_FULL    = 32'sd720000000;
  localparam logic signed [31:0] ANG_HALF    = 32'sd360000000;
  localparam logic signed [31:0] ANG_QUARTER = 32'sd180000000;
  localparam logic [31:0] HALF_UDEG_TO_RAD   = 32'd78602642;
  localparam logic signed [CD_W-1:0] CORDIC_GAIN_INV = 34'sd652032874;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [SEG_W-1:0]   SEG_MAX   = {SEG_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic [30:0] atan_step(input int i);
    logic [30:0] r;
    case (i)
      0:  r = 31'd843314857;
      1:  r = 31'd497837829;
      2:  r = 31'd263043837;
      3:  r = 31'd133525159;
      4:  r = 31'd67021687;
      5:  r = 31'd33543516;
      6:  r = 31'd16775851;
      7:  r = 31'd8388437;
      8:  r = 31'd4194283;
      9:  r = 31'd2097149;
      10: r = 31'd1048576;
      default: r = (i <= 30) ? (31'd1 << (30 - i)) : 31'd0;
    endcase
    return r;
  endfunction

endpackage

@@ design/pgcd_if.sv @@
// ----------------------------------------------------------------------------
// pgcd channel interfaces
// Valid/ready channels for path points and distance results.
// ----------------------------------------------------------------------------
interface pgcd_point_if;
  logic                                valid;
  logic                                ready;
  logic signed [pgcd_pkg::LAT_W-1:0]   latitude_udeg;
  logic signed [pgcd_pkg::LON_W-1:0]   longitude_udeg;
  logic                                path_start;
  modport source (output valid, latitude_udeg, longitude_udeg, path_start, input ready);
  modport sink (input valid, latitude_udeg, longitude_udeg, path_start, output ready);
endinterface

interface pgcd_result_if;
  logic                              valid;
  logic                              ready;
  logic [pgcd_pkg::SEG_W-1:0]        segment_cm;
  logic [pgcd_pkg::TOTAL_W-1:0]      total_cm;
  logic                              over_limit;
  modport source (output valid, segment_cm, total_cm, over_limit, input ready);
  modport sink (input valid, segment_cm, total_cm, over_limit, output ready);
endinterface

@@ design/path_great_circle_distance_unit.sv @@
// ----------------------------------------------------------------------------
// path_great_circle_distance_unit
// Haversine segment length and running path total for a stream of points.
// ----------------------------------------------------------------------------
// Usage:
//   point  : one beat per path point (latitude/longitude in microdegrees,
//            path_start). ready is high only while the unit is idle.
//   result : one beat per point: segment_cm, saturating total_cm and
//            over_limit (total above limit_cm).
//   cfg_*  : write earth_radius_m (index 0) or limit_cm (index 1) while idle.
// Sequence: a path-start point, or the first point after reset, goes from
//   idle straight to the done state and then to the output register. A
//   regular point takes four rotation passes and one vectoring pass of the
//   shared CORDIC, a 31-step two-lane square root and nine passes through
//   the shared multiplier. ready returns with the result, so the unit takes
//   no new point before it is through with the last one.
// Reset: total, previous point and output beat cleared, radius 6371000 m,
//   limit 10000 cm. No point is held, so the first point gives segment 0.
// Stall: a result that is not taken sits in the output register; the unit
//   already accepts the next point and holds its own result until the slot
//   frees.
// ----------------------------------------------------------------------------
`include "path_great_circle_distance_unit_macros.svh"

module path_great_circle_distance_unit #(
  parameter int CORDIC_ITERATIONS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [pgcd_pkg::CFG_W-1:0]    cfg_data,
  pgcd_point_if.sink                    point,
  pgcd_result_if.source                 result
);
  localparam int W = pgcd_pkg::CD_W;

  typedef enum logic [15:0] {
    S_IDLE      = 16'h0001,
    S_REDUCE    = 16'h0002,
    S_ANG_MUL   = 16'h0004,
    S_ANG_Z     = 16'h0008,
    S_ROT_WAIT  = 16'h0010,
    S_MUL_HL    = 16'h0020,
    S_MUL_HN    = 16'h0040,
    S_MUL_C12   = 16'h0080,
    S_MUL_T     = 16'h0100,
    S_SUM       = 16'h0200,
    S_SQRT_GO   = 16'h0400,
    S_SQRT_WAIT = 16'h0800,
    S_VEC_WAIT  = 16'h1000,
    S_SEG_MUL   = 16'h2000,
    S_SEG       = 16'h4000,
    S_DONE      = 16'h8000
  } state_t;

  state_t state;

  // configuration
  logic [pgcd_pkg::RAD_W-1:0]   earth_radius_m;
  logic [pgcd_pkg::LIMIT_W-1:0] limit_cm;

  // path state
  logic signed [pgcd_pkg::LAT_W-1:0] prev_lat;
  logic signed [pgcd_pkg::LON_W-1:0] prev_lon;
  logic signed [pgcd_pkg::LAT_W-1:0] cur_lat;
  logic signed [pgcd_pkg::LON_W-1:0] cur_lon;
  logic                              have_prev;
  logic [pgcd_pkg::TOTAL_W-1:0]      total;
  logic [pgcd_pkg::SEG_W-1:0]        seg;

  // working registers
  logic [1:0]         ang_k;
  logic               red_neg;
  logic               red_sign;
  logic [27:0]        red_mag;
  logic signed [31:0] sl, sn, c1, c2;
  logic [31:0]        hl, hn;
  logic               prod_neg;
  logic [30:0]        a_q;
  logic [31:0]        zc;

  // output slot
  logic                         out_valid;
  logic [pgcd_pkg::SEG_W-1:0]   out_seg;
  logic [pgcd_pkg::TOTAL_W-1:0] out_total;
  logic                         out_over;

  // shared units
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  pgcd_pkg::cordic_ctrl_t cordic_ctrl;
  pgcd_pkg::unit_stat_t   cordic_stat;
  pgcd_pkg::unit_stat_t   sqrt_stat;
  logic signed [W-1:0] cx0, cy0, cz0, cx, cy, cz;
  logic [30:0] sq_y, sq_x;
  logic        sqrt_start;

  logic        in_fire;
  logic        slot_free;
  logic signed [31:0] ang_v;
  logic signed [31:0] wrap_r;
  logic signed [31:0] fold_r;
  logic        fold_neg;
  logic [31:0] rnd30;
  logic [31:0] zmag;
  logic signed [33:0] a_sum;
  logic [30:0] rad200;
  logic [33:0] seg_raw;
  logic [pgcd_pkg::SEG_W-1:0] seg_sat;
  logic [pgcd_pkg::TOTAL_W:0] total_sum;

  assign in_fire   = point.valid && point.ready;
  assign slot_free = !out_valid || result.ready;
  assign point.ready = (state == S_IDLE);

  pgcd_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  pgcd_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
    .clk(clk), .rst(rst), .ctrl(cordic_ctrl),
    .x0(cx0), .y0(cy0), .z0(cz0), .x(cx), .y(cy), .z(cz), .stat(cordic_stat)
  );

  pgcd_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start),
    .op0({a_q, 30'd0}),
    .op1({31'(pgcd_pkg::Q30_ONE - a_q), 30'd0}),
    .root0(sq_y), .root1(sq_x), .stat(sqrt_stat)
  );

  // angle select and range reduction: wrap to one turn, then fold past 90 deg
  always_comb begin
    unique case (ang_k)
      2'd0:    ang_v = 32'(cur_lat) - 32'(prev_lat);
      2'd1:    ang_v = 32'(cur_lon) - 32'(prev_lon);
      2'd2:    ang_v = 32'(prev_lat) <<< 1;
      default: ang_v = 32'(cur_lat) <<< 1;
    endcase
    if (ang_v >= pgcd_pkg::ANG_HALF)       wrap_r = ang_v - pgcd_pkg::ANG_FULL;
    else if (ang_v < -pgcd_pkg::ANG_HALF)  wrap_r = ang_v + pgcd_pkg::ANG_FULL;
    else                                    wrap_r = ang_v;
    fold_neg = 1'b1;
    if (wrap_r > pgcd_pkg::ANG_QUARTER)        fold_r = wrap_r - pgcd_pkg::ANG_HALF;
    else if (wrap_r < -pgcd_pkg::ANG_QUARTER)  fold_r = wrap_r + pgcd_pkg::ANG_HALF;
    else begin
      fold_r   = wrap_r;
      fold_neg = 1'b0;
    end
  end

  // rounding of the shared product
  always_comb begin
    rnd30     = 32'((prod + 64'd536870912) >> 30);
    zmag      = 32'((prod + 64'd4194304) >> 23);
    a_sum     = 34'(hl) + (prod_neg ? -34'(rnd30) : 34'(rnd30));
    rad200    = (31'(earth_radius_m) << 7) + (31'(earth_radius_m) << 6)
              + (31'(earth_radius_m) << 3);
    seg_raw   = 34'((prod + 64'd536870912) >> 30);
    seg_sat   = (seg_raw > 34'(pgcd_pkg::SEG_MAX)) ? pgcd_pkg::SEG_MAX : 31'(seg_raw);
    total_sum = {1'b0, total} + (pgcd_pkg::TOTAL_W + 1)'(seg_sat);
  end

  // operand steering for the shared units
  always_comb begin
    mul_a       = '0;
    mul_b       = '0;
    cordic_ctrl = '{start: 1'b0, vectoring: 1'b0};
    cx0         = pgcd_pkg::CORDIC_GAIN_INV;
    cy0         = '0;
    cz0         = red_sign ? -W'(zmag) : W'(zmag);
    sqrt_start  = 1'b0;
    unique case (state)
      S_ANG_MUL: begin
        mul_a = 32'(red_mag);
        mul_b = pgcd_pkg::HALF_UDEG_TO_RAD;
      end
      S_ANG_Z: cordic_ctrl = '{start: 1'b1, vectoring: 1'b0};
      S_MUL_HL: begin
        mul_a = sl[31] ? 32'(-sl) : 32'(sl);
        mul_b = sl[31] ? 32'(-sl) : 32'(sl);
      end
      S_MUL_HN: begin
        mul_a = sn[31] ? 32'(-sn) : 32'(sn);
        mul_b = sn[31] ? 32'(-sn) : 32'(sn);
      end
      S_MUL_C12: begin
        mul_a = c1[31] ? 32'(-c1) : 32'(c1);
        mul_b = c2[31] ? 32'(-c2) : 32'(c2);
      end
      S_MUL_T: begin
        mul_a = rnd30;
        mul_b = hn;
      end
      S_SQRT_GO: sqrt_start = 1'b1;
      S_SQRT_WAIT: begin
        cx0 = W'(sq_x);
        cy0 = W'(sq_y);
        cz0 = '0;
        cordic_ctrl = '{start: sqrt_stat.done, vectoring: 1'b1};
      end
      S_SEG_MUL: begin
        mul_a = 32'(rad200);
        mul_b = zc;
      end
      default: ;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      earth_radius_m <= pgcd_pkg::RADIUS_RESET;
      limit_cm       <= pgcd_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pgcd_pkg::REG_EARTH_RADIUS: earth_radius_m <= cfg_data[pgcd_pkg::RAD_W-1:0];
        pgcd_pkg::REG_LIMIT:        limit_cm       <= cfg_data[pgcd_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and path state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      have_prev <= 1'b0;
      total     <= '0;
      prev_lat  <= '0;
      prev_lon  <= '0;
      out_valid <= 1'b0;
    end else begin
      // load the slot from a finished point, else drop a taken beat
      if (state == S_DONE && slot_free) out_valid <= 1'b1;
      else if (result.ready)            out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            cur_lat <= point.latitude_udeg;
            cur_lon <= point.longitude_udeg;
            seg     <= '0;
            ang_k   <= 2'd0;
            if (point.path_start) begin
              total <= '0;
              state <= S_DONE;
            end else if (!have_prev) begin
              state <= S_DONE;
            end else begin
              state <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          red_neg  <= fold_neg;
          red_sign <= fold_r[31];
          red_mag  <= fold_r[31] ? 28'(-fold_r) : 28'(fold_r);
          state    <= S_ANG_MUL;
        end
        S_ANG_MUL: state <= S_ANG_Z;
        S_ANG_Z:   state <= S_ROT_WAIT;
        S_ROT_WAIT: begin
          if (cordic_stat.done) begin
            unique case (ang_k)
              2'd0:    sl <= red_neg ? 32'(-cy) : 32'(cy);
              2'd1:    sn <= red_neg ? 32'(-cy) : 32'(cy);
              2'd2:    c1 <= red_neg ? 32'(-cx) : 32'(cx);
              default: c2 <= red_neg ? 32'(-cx) : 32'(cx);
            endcase
            ang_k <= ang_k + 2'd1;
            state <= (ang_k == 2'd3) ? S_MUL_HL : S_REDUCE;
          end
        end
        S_MUL_HL: state <= S_MUL_HN;
        S_MUL_HN: begin
          hl    <= rnd30;
          state <= S_MUL_C12;
        end
        S_MUL_C12: begin
          hn       <= rnd30;
          prod_neg <= c1[31] ^ c2[31];
          state    <= S_MUL_T;
        end
        S_MUL_T: state <= S_SUM;
        S_SUM: begin
          // clamp to [0, 1.0]
          if (a_sum[33])                       a_q <= '0;
          else if (a_sum > 34'(pgcd_pkg::Q30_ONE)) a_q <= pgcd_pkg::Q30_ONE;
          else                                 a_q <= 31'(a_sum);
          state <= S_SQRT_GO;
        end
        S_SQRT_GO: state <= S_SQRT_WAIT;
        S_SQRT_WAIT: if (sqrt_stat.done) state <= S_VEC_WAIT;
        S_VEC_WAIT: begin
          if (cordic_stat.done) begin
            zc    <= cz[W-1] ? 32'd0 : 32'(cz);
            state <= S_SEG_MUL;
          end
        end
        S_SEG_MUL: state <= S_SEG;
        S_SEG: begin
          // hold the saturated segment and add it to the total, saturating
          seg   <= seg_sat;
          total <= total_sum[pgcd_pkg::TOTAL_W] ? pgcd_pkg::TOTAL_MAX
                 : total_sum[pgcd_pkg::TOTAL_W-1:0];
          state <= S_DONE;
        end
        S_DONE: begin
          if (slot_free) begin
            out_seg   <= seg;
            out_total <= total;
            out_over  <= (total > 48'(limit_cm));
            prev_lat  <= cur_lat;
            prev_lon  <= cur_lon;
            have_prev <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid      = out_valid;
  assign result.segment_cm = out_seg;
  assign result.total_cm   = out_total;
  assign result.over_limit = out_over;

  `PGCD_ASSERT_NEXT(a_busy_after_beat, in_fire, !point.ready, "point taken while busy")
  `PGCD_ASSERT_HOLDS(a_cordic_owned, cordic_stat.busy, state == S_ROT_WAIT || state == S_VEC_WAIT, "cordic runs outside its wait states")
  `PGCD_ASSERT_HOLDS(a_flag_matches, result.valid, result.over_limit == (result.total_cm > 48'(limit_cm)), "over_limit disagrees with total")
endmodule

@@ design/pgcd_mul.sv @@
// ----------------------------------------------------------------------------
// pgcd_mul
// Shared registered 32x32 unsigned multiplier.
// ----------------------------------------------------------------------------
module pgcd_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);
  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end
endmodule

@@ design/pgcd_sqrt.sv @@
// ----------------------------------------------------------------------------
// pgcd_sqrt
// Two-lane digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module pgcd_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pgcd_pkg::SQ_W-1:0]   op0,
  input  logic [pgcd_pkg::SQ_W-1:0]   op1,
  output logic [30:0]                 root0,
  output logic [30:0]                 root1,
  output pgcd_pkg::unit_stat_t        stat
);
  localparam int W = pgcd_pkg::SQ_W;

  logic [W-1:0] rem [2];
  logic [W:0]   root [2];
  logic [W-1:0] bitv;
  logic         busy;
  logic         done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bitv[0]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem[0]  <= op0;
      rem[1]  <= op1;
      root[0] <= '0;
      root[1] <= '0;
      bitv    <= {1'b1, {(W-1){1'b0}}};
    end else if (busy) begin
      for (int l = 0; l < 2; l++) begin
        if ({1'b0, rem[l]} >= root[l] + {1'b0, bitv}) begin
          rem[l]  <= W'({1'b0, rem[l]} - root[l] - {1'b0, bitv});
          root[l] <= (root[l] >> 1) + {1'b0, bitv};
        end else begin
          root[l] <= root[l] >> 1;
        end
      end
      bitv <= bitv >> 2;
    end
  end

  assign root0 = root[0][30:0];
  assign root1 = root[1][30:0];
  assign stat  = '{busy: busy, done: done};
endmodule

@@ design/pgcd_cordic.sv @@
// ----------------------------------------------------------------------------
// pgcd_cordic
// Shared circular CORDIC, rotation or vectoring, one step per cycle.
// ----------------------------------------------------------------------------
module pgcd_cordic #(
  parameter int ITERATIONS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pgcd_pkg::cordic_ctrl_t            ctrl,
  input  logic signed [pgcd_pkg::CD_W-1:0]  x0,
  input  logic signed [pgcd_pkg::CD_W-1:0]  y0,
  input  logic signed [pgcd_pkg::CD_W-1:0]  z0,
  output logic signed [pgcd_pkg::CD_W-1:0]  x,
  output logic signed [pgcd_pkg::CD_W-1:0]  y,
  output logic signed [pgcd_pkg::CD_W-1:0]  z,
  output pgcd_pkg::unit_stat_t              stat
);
  localparam int W  = pgcd_pkg::CD_W;
  localparam int CW = $clog2(ITERATIONS);
  localparam logic [CW-1:0] LAST = CW'(ITERATIONS - 1);

  logic [CW-1:0]       iter;
  logic                busy;
  logic                done;
  logic                vec;
  logic                up;
  logic signed [W-1:0] xs;
  logic signed [W-1:0] ys;
  logic signed [W-1:0] at;

  always_comb begin
    xs = x >>> iter;
    ys = y >>> iter;
    at = W'(signed'({1'b0, pgcd_pkg::atan_step(int'(iter))}));
    up = vec ? y[W-1] : !z[W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
      end else if (busy && iter == LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      x    <= x0;
      y    <= y0;
      z    <= z0;
      vec  <= ctrl.vectoring;
      iter <= '0;
    end else if (busy) begin
      if (up) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
      iter <= iter + 1'b1;
    end
  end

  assign stat = '{busy: busy, done: done};
endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// Path great-circle distance unit testbench
// Drives path points through the point channel, predicts segment length,
// running total and over-limit flag for each accepted beat, and checks every
// result beat in order. It runs under several radius and limit settings.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LAT_W   = pgcd_pkg::LAT_W;
  localparam int LON_W   = pgcd_pkg::LON_W;
  localparam int SEG_W   = pgcd_pkg::SEG_W;
  localparam int TOTAL_W = pgcd_pkg::TOTAL_W;
  localparam int RAD_W   = pgcd_pkg::RAD_W;
  localparam int CFG_W   = pgcd_pkg::CFG_W;

  localparam int ITERS      = 24;
  localparam int DRAIN_WAIT = 250;   // above the point latency
  localparam int WDOG_LIMIT = 6000;  // longest stall plus latency, several times over

  typedef struct {
    logic [SEG_W-1:0]   segment_cm;
    logic [TOTAL_W-1:0] total_cm;
    logic               over_limit;
  } distance_t;

  // Path distance predictor and store of pending distance beats.
  class distance_board;
    longint unsigned radius_m;
    longint unsigned limit_cm;
    longint          last_lat;
    longint          last_lon;
    bit              have_last;
    longint unsigned total;
    distance_t       pending[$];
    int              mismatches;

    function void init();
      radius_m  = pgcd_pkg::RADIUS_RESET;
      limit_cm  = pgcd_pkg::LIMIT_RESET;
      last_lat  = 0;
      last_lon  = 0;
      have_last = 0;
      total     = 0;
    endfunction

    function longint atan_q30(int i);
      if (i <= 30) return longint'(pgcd_pkg::atan_step(i));
      return 0;
    endfunction

    // Q30 product, rounded half away from zero
    function longint qmul(longint a, longint b);
      longint unsigned ma, mb, r;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      r = (ma * mb + (64'd1 << 29)) >> 30;
      return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    // sin and cos (Q30) of an angle in half-microdegrees
    function void sin_cos(longint v, output longint s, output longint c);
      longint r, z, x, y, m, dx, dy;
      bit flip;
      flip = 0;
      r = v % 720000000;
      if (r >= 360000000) r -= 720000000;
      if (r < -360000000) r += 720000000;
      if (r > 180000000) begin
        r -= 360000000;
        flip = 1;
      end else if (r < -180000000) begin
        r += 360000000;
        flip = 1;
      end
      m = (r < 0) ? -r : r;
      z = (m * 78602642 + (64'sd1 << 22)) >>> 23;
      if (r < 0) z = -z;
      x = pgcd_pkg::CORDIC_GAIN_INV;
      y = 0;
      for (int i = 0; i < ITERS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_q30(i);
        end else begin
          x += dx; y -= dy; z += atan_q30(i);
        end
      end
      if (flip) begin
        x = -x; y = -y;
      end
      s = y;
      c = x;
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root, b;
      root = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= root + b) begin
          n -= root + b;
          root = (root >> 1) + b;
        end else begin
          root >>= 1;
        end
        b >>= 2;
      end
      return root;
    endfunction

    function longint unsigned segment(longint la1, longint lo1, longint la2, longint lo2);
      longint sl, sn, c1, c2, dummy, a, x, y, z, dx, dy;
      longint unsigned seg;
      sin_cos(la2 - la1, sl, dummy);
      sin_cos(lo2 - lo1, sn, dummy);
      sin_cos(2 * la1, dummy, c1);
      sin_cos(2 * la2, dummy, c2);
      a = qmul(sl, sl) + qmul(qmul(c1, c2), qmul(sn, sn));
      if (a < 0) a = 0;
      if (a > (64'sd1 << 30)) a = 64'sd1 << 30;
      y = int_sqrt(longint'(a) << 30);
      x = int_sqrt(((64'sd1 << 30) - a) << 30);
      z = 0;
      for (int i = 0; i < ITERS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += atan_q30(i);
        end else begin
          x -= dx; y += dy; z -= atan_q30(i);
        end
      end
      if (z < 0) z = 0;
      seg = (radius_m * 200 * longint'(z) + (64'd1 << 29)) >> 30;
      return (seg > pgcd_pkg::SEG_MAX) ? pgcd_pkg::SEG_MAX : seg;
    endfunction

    function void note_point(logic signed [LAT_W-1:0] lat, logic signed [LON_W-1:0] lon,
                             logic start);
      distance_t d;
      longint unsigned seg;
      seg = 0;
      if (start) begin
        total = 0;
      end else if (have_last) begin
        seg = segment(last_lat, last_lon, longint'(lat), longint'(lon));
        total += seg;
        if (total > pgcd_pkg::TOTAL_MAX) total = pgcd_pkg::TOTAL_MAX;
      end
      last_lat  = lat;
      last_lon  = lon;
      have_last = 1;
      d.segment_cm = SEG_W'(seg);
      d.total_cm   = TOTAL_W'(total);
      d.over_limit = total > limit_cm;
      pending.push_back(d);
    endfunction

    function void check_result(distance_t got);
      distance_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: seg %0d total %0d over %0b",
                                       got.segment_cm, got.total_cm, got.over_limit);
        return;
      end
      want = pending.pop_front();
      if (got.segment_cm !== want.segment_cm || got.total_cm !== want.total_cm ||
          got.over_limit !== want.over_limit) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: seg %0d/%0d total %0d/%0d over %0b/%0b (exp/act)",
                   want.segment_cm, got.segment_cm, want.total_cm, got.total_cm,
                   want.over_limit, got.over_limit);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;

  pgcd_point_if  point ();
  pgcd_result_if result ();

  path_great_circle_distance_unit #(.CORDIC_ITERATIONS(ITERS)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .point     (point),
    .result    (result)
  );

  distance_board board;
  int  sink_busy_pct;     // chance per cycle that the sink holds off
  bit  long_hold_req;     // ask the sink for one long hold-off
  int  quiet_cycles;

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // Result side: check each beat, then pick ready for the next edge.
  initial begin
    int hold_left;
    distance_t got;
    hold_left = 0;
    result.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result.valid && result.ready) begin
        got.segment_cm = result.segment_cm;
        got.total_cm   = result.total_cm;
        got.over_limit = result.over_limit;
        board.check_result(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        result.ready <= 1'b0;
      end else if (long_hold_req) begin
        // hold long enough that the unit finishes a second point and stalls its input
        long_hold_req = 0;
        hold_left = 600;
        result.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 2 && sink_busy_pct > 0) begin
        hold_left = $urandom_range(20, 300);
        result.ready <= 1'b0;
      end else begin
        result.ready <= ($urandom_range(0, 99) >= sink_busy_pct);
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (rst || (point.valid && point.ready) || (result.valid && result.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  int src_busy_pct;

  // Offer one point; hold valid through the gap-free case so a new point waits as soon as the last is taken.
  task automatic send_point(logic signed [LAT_W-1:0] lat, logic signed [LON_W-1:0] lon,
                            logic start);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < src_busy_pct)
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 400) : $urandom_range(1, 6);
    if (gap > 0) begin
      point.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    point.valid          <= 1'b1;
    point.latitude_udeg  <= lat;
    point.longitude_udeg <= lon;
    point.path_start     <= start;
    do @(posedge clk); while (!point.ready);
    board.note_point(lat, lon, start);
  endtask

  task automatic drain();
    point.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == pgcd_pkg::REG_EARTH_RADIUS) board.radius_m = value[RAD_W-1:0];
    else board.limit_cm = value;
  endtask

  // Random part: mostly GPS-like paths, some jumps, some raw-bit noise.
  task automatic random_points(int count);
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
    int sent, len;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        lat = LAT_W'($urandom());
        lon = LON_W'($urandom());
        send_point(lat, lon, 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        lat = LAT_W'($urandom_range(0, 180000000) - 90000000);
        lon = LON_W'($urandom_range(0, 360000000) - 180000000);
        send_point(lat, lon, $urandom_range(0, 4) != 0);
        len = $urandom_range(3, 30);
        for (int k = 0; k < len && sent < count; k++) begin
          if ($urandom_range(0, 15) == 0) begin
            lat = LAT_W'($urandom_range(0, 180000000) - 90000000);
            lon = LON_W'($urandom_range(0, 360000000) - 180000000);
          end else begin
            lat = LAT_W'(lat + $signed($urandom_range(0, 200000)) - 100000);
            lon = LON_W'(lon + $signed($urandom_range(0, 200000)) - 100000);
          end
          send_point(lat, lon, 1'b0);
          sent++;
        end
      end
    end
  endtask

  initial begin
    board = new();
    board.init();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = pgcd_pkg::REG_EARTH_RADIUS;
    cfg_data = '0;
    point.valid = 1'b0;
    point.latitude_udeg = '0;
    point.longitude_udeg = '0;
    point.path_start = 1'b0;
    sink_busy_pct = 0;
    src_busy_pct = 0;
    long_hold_req = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: first point without a previous one, then path start and extremes.
    send_point(28'sd1000, 29'sd2000, 1'b0);
    send_point(28'sd1000, 29'sd2000, 1'b0);           // zero-length segment
    send_point(28'sd0, 29'sd0, 1'b1);
    send_point(28'sd90000000, 29'sd180000000, 1'b0);
    send_point(-28'sd90000000, -29'sd180000000, 1'b0);
    send_point(28'sd0, 29'sd0, 1'b0);
    send_point(28'sd0, 29'sd180000000, 1'b0);         // antipodal on the equator
    send_point({1'b1, {(LAT_W-1){1'b0}}}, {1'b1, {(LON_W-1){1'b0}}}, 1'b0);
    send_point({1'b0, {(LAT_W-1){1'b1}}}, {1'b0, {(LON_W-1){1'b1}}}, 1'b0);
    send_point(28'sd89999999, 29'sd0, 1'b0);
    send_point(-28'sd89999999, 29'sd1, 1'b0);         // near pole to pole
    send_point(28'sd45000000, -29'sd179999999, 1'b1);
    send_point(28'sd45000001, 29'sd179999999, 1'b0);  // across the date line
    drain();

    // Largest radius on an antipodal hop saturates the segment.
    write_reg(pgcd_pkg::REG_EARTH_RADIUS, 32'd7000000);
    write_reg(pgcd_pkg::REG_LIMIT, 32'd0);
    send_point(28'sd0, 29'sd0, 1'b1);
    send_point(28'sd0, 29'sd180000000, 1'b0);
    send_point(28'sd0, 29'sd0, 1'b0);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(pgcd_pkg::REG_EARTH_RADIUS, 32'd6000000);
          write_reg(pgcd_pkg::REG_LIMIT, 32'hFFFF_FFFF);
          sink_busy_pct = 0;
          src_busy_pct = 0;
        end
        1: begin
          write_reg(pgcd_pkg::REG_EARTH_RADIUS, 32'd6371000);
          write_reg(pgcd_pkg::REG_LIMIT, 32'd10000);
          sink_busy_pct = 30;
          src_busy_pct = 30;
          long_hold_req = 1;
        end
        2: begin
          write_reg(pgcd_pkg::REG_EARTH_RADIUS, 32'd7000000);
          write_reg(pgcd_pkg::REG_LIMIT, $urandom());
          sink_busy_pct = 60;
          src_busy_pct = 10;
        end
        default: begin
          write_reg(pgcd_pkg::REG_EARTH_RADIUS, $urandom_range(6000000, 7000000));
          write_reg(pgcd_pkg::REG_LIMIT, $urandom_range(0, 50000000));
          sink_busy_pct = 15;
          src_busy_pct = 50;
        end
      endcase
      random_points(200);
      if (phase == 1) drain();  // pause the source until every beat is back
      random_points(200);
      drain();
    end

    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
